// ===== rtl/core/fcti_pkg.sv =====
// fan curve table interpolator: shared codes, types and widths
// used by the controller, the datapath and the top level
package fcti_pkg;

   localparam int TEMP_W = 13;
   localparam int DUTY_W = 8;
   localparam int PT_W   = TEMP_W + DUTY_W;
   localparam int CNT_W  = 5;

   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_UPSERT = 2'd1;
   localparam logic [1:0] ACT_REMOVE = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_NO_SPACE  = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_DECODE, S_SCAN, S_WRITE, S_LK_CNT, S_LK_LAST, S_LK_CLAMP,
      S_LK_SEG, S_LK_CHK, S_MUL, S_SUM, S_DIV, S_DONE
   } ctl_state_type;

   typedef enum logic [1:0] {
      DK_DONE, DK_SCAN, DK_WRITE, DK_LOOKUP
   } dec_kind_type;

   typedef struct packed {
      logic load;
      logic decode;
      logic scan;
      logic write;
      logic lk_cnt;
      logic lk_last;
      logic lk_clamp;
      logic lk_seg;
      logic lk_chk;
      logic mul;
      logic sum;
      logic div;
   } cmd_type;

   typedef struct packed {
      dec_kind_type dec_kind;
      logic         scan_hit;
      logic         scan_end;
      logic         n_zero;
      logic         clamp_hit;
      logic         seg_hit;
      logic         seg_zero;
      logic         seg_end;
      logic         div_last;
   } sts_type;

endpackage

// ===== rtl/core/fan_curve_table_interpolator.sv =====
// fan curve table interpolator top level: controller plus datapath
// uses fcti_pkg, fcti_ctrl, fcti_datapath (which holds the fcti_ram instances)
//
// channel   direction  handshake          ports
// request   in         start && !busy     req_action .. req_temperature
// result    out        rsp_valid strobe   rsp_status, rsp_duty, rsp_slot_id,
//                                         rsp_curve_count
//
// one word at a time; busy stays high from the accept edge until the strobe cycle
// remove and rejected words: decode, then the strobe; upsert point: decode, point write
// and strobe, with a slot scan before the write when point 0 needs a free slot
// lookup: decode, count read, last point read and clamp check; else a read and a check
// per segment from the point ram, then multiply, sum and the 8-step divide
// synchronous reset clears slot map, count and upsert state; point data is not cleared
// the rsp_valid strobe is high for exactly one cycle; the receiver cannot stall it
module fan_curve_table_interpolator #(
   parameter int CURVES = 8,
   parameter int POINTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic [7:0]         req_curve_id,
   input  logic [3:0]         req_point_index,
   input  logic [7:0]         req_point_count,
   input  logic signed [12:0] req_point_temp,
   input  logic [7:0]         req_point_duty,
   input  logic signed [12:0] req_temperature,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [7:0]         rsp_duty,
   output logic [2:0]         rsp_slot_id,
   output logic [3:0]         rsp_curve_count
);
   import fcti_pkg::*;

   cmd_type cmd;
   sts_type sts;

   fcti_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   fcti_datapath #(.CURVES(CURVES), .POINTS(POINTS)) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_action),
      .req_curve_id    (req_curve_id),
      .req_point_index (req_point_index),
      .req_point_count (req_point_count),
      .req_point_temp  (req_point_temp),
      .req_point_duty  (req_point_duty),
      .req_temperature (req_temperature),
      .rsp_status      (rsp_status),
      .rsp_duty        (rsp_duty),
      .rsp_slot_id     (rsp_slot_id),
      .rsp_curve_count (rsp_curve_count)
   );

endmodule

// ===== rtl/core/fcti_ram.sv =====
// generic single write, single read ram with registered read data
// no package dependencies
module fcti_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/fcti_datapath.sv =====
// datapath: request registers, slot bookkeeping, point and count rams,
// segment scan, interpolation multiply and restoring divide; uses fcti_pkg, fcti_ram
module fcti_datapath #(
   parameter int CURVES = 8,
   parameter int POINTS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fcti_pkg::cmd_type               cmd,
   output fcti_pkg::sts_type               sts,
   input  logic [1:0]                      req_action,
   input  logic [7:0]                      req_curve_id,
   input  logic [3:0]                      req_point_index,
   input  logic [7:0]                      req_point_count,
   input  logic signed [12:0]              req_point_temp,
   input  logic [7:0]                      req_point_duty,
   input  logic signed [12:0]              req_temperature,
   output logic [1:0]                      rsp_status,
   output logic [7:0]                      rsp_duty,
   output logic [2:0]                      rsp_slot_id,
   output logic [3:0]                      rsp_curve_count
);
   import fcti_pkg::*;

   localparam int SW = (CURVES > 1) ? $clog2(CURVES) : 1;
   localparam int AW = $clog2(CURVES * POINTS);
   localparam int UW = $clog2(CURVES + 1);
   localparam logic [AW-1:0] PTS_A = AW'(POINTS);
   localparam logic [SW-1:0] LAST_SLOT = SW'(CURVES - 1);

   // request word
   logic [1:0]         action_ff;
   logic [7:0]         id_ff;
   logic [3:0]         pidx_ff;
   logic [7:0]         pcnt_ff;
   logic signed [12:0] ptemp_ff;
   logic [7:0]         pduty_ff;
   logic signed [12:0] temp_ff;

   // slot bookkeeping
   logic [CURVES-1:0]  in_use_ff;
   logic [UW-1:0]      used_ff;
   logic [SW-1:0]      open_slot_ff;
   logic               open_ff;
   logic [3:0]         expect_ff;

   // working registers
   logic [SW-1:0]      slot_ff;
   logic [SW-1:0]      scan_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [CNT_W-1:0]   seg_ff;
   logic signed [12:0] prev_t_ff;
   logic [7:0]         prev_d_ff;
   logic [13:0]        range_ff;
   logic [13:0]        dt_ff;
   logic [7:0]         d0_ff;
   logic signed [8:0]  dd_ff;
   logic [21:0]        p0_ff;
   logic signed [23:0] p1_ff;
   logic [23:0]        rem_ff;
   logic [23:0]        div_ff;
   logic [7:0]         q_ff;
   logic [2:0]         step_ff;

   logic [1:0]         status_ff;
   logic [7:0]         duty_ff;
   logic [SW-1:0]      slot_res_ff;

   // decode
   logic               id_ok;
   logic [SW-1:0]      id_slot;
   logic               in_use_id;
   logic               cnt_bad;
   dec_kind_type       dec_kind;
   logic [1:0]         dec_status;
   logic               dec_close;
   logic               dec_remove;
   logic [SW-1:0]      dec_slot;

   // rams
   logic               pt_we;
   logic [AW-1:0]      pt_waddr;
   logic [AW-1:0]      pt_raddr;
   logic [PT_W-1:0]    pt_rdata;
   logic [CNT_W-1:0]   cnt_rdata;
   logic [AW-1:0]      pt_off;
   logic [SW-1:0]      rd_slot;

   logic signed [12:0] cur_t;
   logic [7:0]         cur_d;
   logic               seg_hit;
   logic               free_hit;
   logic signed [23:0] num;
   logic [23:0]        num_pos;
   logic               div_ge;
   logic [7:0]         q_next;

   assign id_ok     = id_ff < 8'(CURVES);
   assign id_slot   = id_ff[SW-1:0];
   assign in_use_id = id_ok && in_use_ff[id_slot];
   assign cnt_bad   = (pcnt_ff == 8'd0) || (pcnt_ff > 8'(POINTS)) ||
                      ({4'd0, pidx_ff} >= pcnt_ff);

   always_comb begin
      dec_kind   = DK_DONE;
      dec_status = ST_OK;
      dec_close  = 1'b0;
      dec_remove = 1'b0;
      dec_slot   = id_slot;
      unique case (action_ff)
         ACT_LOOKUP: begin
            if (!id_ok) begin
               dec_status = ST_INVALID;
            end else if (!in_use_id) begin
               dec_status = ST_NOT_FOUND;
            end else begin
               dec_kind = DK_LOOKUP;
            end
         end
         ACT_UPSERT: begin
            if (cnt_bad) begin
               dec_status = ST_INVALID;
               dec_close  = 1'b1;
            end else if (pidx_ff == 4'd0) begin
               dec_close = 1'b1;
               dec_kind  = in_use_id ? DK_WRITE : DK_SCAN;
            end else if (!open_ff || (pidx_ff != expect_ff)) begin
               dec_status = ST_INVALID;
               dec_close  = 1'b1;
            end else begin
               dec_kind = DK_WRITE;
               dec_slot = open_slot_ff;
            end
         end
         ACT_REMOVE: begin
            if (!id_ok) begin
               dec_status = ST_INVALID;
            end else if (!in_use_id) begin
               dec_status = ST_NOT_FOUND;
            end else begin
               dec_remove = 1'b1;
            end
         end
         default: begin
            dec_status = ST_INVALID;
         end
      endcase
   end

   assign cur_t    = pt_rdata[PT_W-1:DUTY_W];
   assign cur_d    = pt_rdata[DUTY_W-1:0];
   assign seg_hit  = (temp_ff >= prev_t_ff) && (temp_ff <= cur_t);
   assign free_hit = !in_use_ff[scan_ff];

   assign num     = $signed({2'b00, p0_ff}) + p1_ff;
   assign num_pos = num[23] ? 24'd0 : num;
   assign div_ge  = rem_ff >= div_ff;
   assign q_next  = {q_ff[6:0], div_ge};

   always_comb begin
      sts.dec_kind  = dec_kind;
      sts.scan_hit  = free_hit;
      sts.scan_end  = !free_hit && (scan_ff == LAST_SLOT);
      sts.n_zero    = cnt_rdata == '0;
      sts.clamp_hit = (temp_ff <= prev_t_ff) || (temp_ff >= cur_t);
      sts.seg_hit   = seg_hit;
      sts.seg_zero  = cur_t == prev_t_ff;
      sts.seg_end   = seg_ff == CNT_W'(n_ff - 1'b1);
      sts.div_last  = step_ff == 3'd7;
   end

   // point ram addressing
   always_comb begin
      priority if (cmd.lk_cnt) begin
         pt_off = '0;
      end else if (cmd.lk_last) begin
         pt_off = AW'(CNT_W'(n_ff - 1'b1));
      end else begin
         pt_off = AW'(seg_ff);
      end
   end

   assign rd_slot  = id_slot;
   assign pt_raddr = AW'(rd_slot) * PTS_A + pt_off;
   assign pt_waddr = AW'(slot_ff) * PTS_A + AW'(pidx_ff);
   assign pt_we    = cmd.write;

   fcti_ram #(.WIDTH(PT_W), .DEPTH(CURVES * POINTS)) u_pt_ram (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (pt_waddr),
      .wr_data ({ptemp_ff, pduty_ff}),
      .rd_addr (pt_raddr),
      .rd_data (pt_rdata)
   );

   fcti_ram #(.WIDTH(CNT_W), .DEPTH(CURVES)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cmd.write),
      .wr_addr (slot_ff),
      .wr_data ({1'b0, pidx_ff} + 5'd1),
      .rd_addr (id_slot),
      .rd_data (cnt_rdata)
   );

   // slot bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff    <= '0;
         used_ff      <= '0;
         open_slot_ff <= '0;
         open_ff      <= 1'b0;
         expect_ff    <= '0;
      end else begin
         if (cmd.decode) begin
            if (dec_close) begin
               open_ff <= 1'b0;
            end
            if (dec_remove) begin
               in_use_ff[id_slot] <= 1'b0;
               used_ff            <= used_ff - 1'b1;
               if (open_ff && (open_slot_ff == id_slot)) begin
                  open_ff <= 1'b0;
               end
            end
         end
         if (cmd.scan && free_hit) begin
            in_use_ff[scan_ff] <= 1'b1;
            used_ff            <= used_ff + 1'b1;
         end
         if (cmd.write) begin
            open_slot_ff <= slot_ff;
            expect_ff    <= pidx_ff + 4'd1;
            open_ff      <= ({4'd0, pidx_ff} + 8'd1) < pcnt_ff;
         end
      end
   end

   // request word, scan and arithmetic
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         id_ff     <= req_curve_id;
         pidx_ff   <= req_point_index;
         pcnt_ff   <= req_point_count;
         ptemp_ff  <= req_point_temp;
         pduty_ff  <= req_point_duty;
         temp_ff   <= req_temperature;
      end
      if (cmd.decode) begin
         status_ff   <= dec_status;
         duty_ff     <= 8'd0;
         slot_res_ff <= '0;
         slot_ff     <= dec_slot;
         scan_ff     <= '0;
      end
      if (cmd.scan) begin
         if (free_hit) begin
            slot_ff <= scan_ff;
         end else if (scan_ff == LAST_SLOT) begin
            status_ff <= ST_NO_SPACE;
         end else begin
            scan_ff <= scan_ff + 1'b1;
         end
      end
      if (cmd.write) begin
         status_ff   <= ST_OK;
         slot_res_ff <= slot_ff;
      end
      if (cmd.lk_cnt) begin
         n_ff <= cnt_rdata;
         if (cnt_rdata == '0) begin
            status_ff <= ST_INVALID;
         end
      end
      if (cmd.lk_last) begin
         prev_t_ff <= cur_t;
         prev_d_ff <= cur_d;
      end
      if (cmd.lk_clamp) begin
         seg_ff <= CNT_W'(1);
         if (temp_ff <= prev_t_ff) begin
            duty_ff <= prev_d_ff;
         end else if (temp_ff >= cur_t) begin
            duty_ff <= cur_d;
         end
      end
      if (cmd.lk_chk) begin
         range_ff <= 14'($signed({cur_t[12], cur_t}) - $signed({prev_t_ff[12], prev_t_ff}));
         dt_ff    <= 14'($signed({temp_ff[12], temp_ff}) -
                         $signed({prev_t_ff[12], prev_t_ff}));
         d0_ff    <= prev_d_ff;
         dd_ff    <= $signed({1'b0, cur_d}) - $signed({1'b0, prev_d_ff});
         if (seg_hit) begin
            duty_ff <= prev_d_ff;
         end else if (seg_ff == CNT_W'(n_ff - 1'b1)) begin
            status_ff <= ST_NOT_FOUND;
         end else begin
            prev_t_ff <= cur_t;
            prev_d_ff <= cur_d;
            seg_ff    <= seg_ff + 1'b1;
         end
      end
      if (cmd.mul) begin
         p0_ff <= d0_ff * range_ff;
         p1_ff <= $signed({1'b0, dt_ff}) * dd_ff;
      end
      if (cmd.sum) begin
         // round half up: (2*num + range) / (2*range)
         rem_ff  <= {num_pos[22:0], 1'b0} + {10'd0, range_ff};
         div_ff  <= {2'b00, range_ff, 8'd0};
         q_ff    <= 8'd0;
         step_ff <= 3'd0;
      end
      if (cmd.div) begin
         if (div_ge) begin
            rem_ff <= rem_ff - div_ff;
         end
         div_ff  <= div_ff >> 1;
         q_ff    <= q_next;
         step_ff <= step_ff + 3'd1;
         if (step_ff == 3'd7) begin
            duty_ff <= q_next;
         end
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_duty        = duty_ff;
   assign rsp_slot_id     = 3'(slot_res_ff);
   assign rsp_curve_count = 4'(used_ff);

   a_used_count: assert property (@(posedge clock) disable iff (reset)
      used_ff == UW'($countones(in_use_ff)))
      else $error("used count differs from slot map");

   a_open_in_use: assert property (@(posedge clock) disable iff (reset)
      open_ff |-> in_use_ff[open_slot_ff])
      else $error("open upsert on a free slot");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.div |-> (div_ff != 24'd0))
      else $error("divide with zero divisor");

endmodule

// ===== rtl/core/fcti_ctrl.sv =====
// controller state machine: sequences decode, slot scan, point write,
// segment scan, multiply and divide; uses fcti_pkg
module fcti_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output fcti_pkg::cmd_type cmd,
   input  fcti_pkg::sts_type sts
);
   import fcti_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.dec_kind)
               DK_SCAN:   state_in = S_SCAN;
               DK_WRITE:  state_in = S_WRITE;
               DK_LOOKUP: state_in = S_LK_CNT;
               default:   state_in = S_DONE;
            endcase
         end
         S_SCAN: begin
            priority if (sts.scan_hit) begin
               state_in = S_WRITE;
            end else if (sts.scan_end) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_WRITE:    state_in = S_DONE;
         S_LK_CNT:   state_in = sts.n_zero ? S_DONE : S_LK_LAST;
         S_LK_LAST:  state_in = S_LK_CLAMP;
         S_LK_CLAMP: state_in = sts.clamp_hit ? S_DONE : S_LK_SEG;
         S_LK_SEG:   state_in = S_LK_CHK;
         S_LK_CHK: begin
            priority if (sts.seg_hit) begin
               state_in = sts.seg_zero ? S_DONE : S_MUL;
            end else if (sts.seg_end) begin
               state_in = S_DONE;
            end else begin
               state_in = S_LK_SEG;
            end
         end
         S_MUL: state_in = S_SUM;
         S_SUM: state_in = S_DIV;
         S_DIV: begin
            if (sts.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      busy         = state_ff != S_IDLE;
      rsp_valid    = state_ff == S_DONE;
      cmd.load     = (state_ff == S_IDLE) && start;
      cmd.decode   = state_ff == S_DECODE;
      cmd.scan     = state_ff == S_SCAN;
      cmd.write    = state_ff == S_WRITE;
      cmd.lk_cnt   = state_ff == S_LK_CNT;
      cmd.lk_last  = state_ff == S_LK_LAST;
      cmd.lk_clamp = state_ff == S_LK_CLAMP;
      cmd.lk_seg   = state_ff == S_LK_SEG;
      cmd.lk_chk   = state_ff == S_LK_CHK;
      cmd.mul      = state_ff == S_MUL;
      cmd.sum      = state_ff == S_SUM;
      cmd.div      = state_ff == S_DIV;
   end

   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while idle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not start work");

   a_valid_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("still busy after result");

endmodule

// ===== bench/fan_curve_table_interpolator_tb.sv =====
// testbench for fan_curve_table_interpolator: directed and random command words,
// results checked against an in-bench curve table predictor; depends on fcti_pkg
module fan_curve_table_interpolator_tb;
   import fcti_pkg::*;

   localparam int NCURVES   = 8;
   localparam int NPOINTS   = 16;
   localparam int IDLE_MAX  = 2000;
   localparam int DRAIN     = 80;
   localparam int ACT_SPARE = 3;

   typedef struct {
      logic [1:0]         action;
      logic [7:0]         curve_id;
      logic [3:0]         point_index;
      logic [7:0]         point_count;
      logic signed [12:0] point_temp;
      logic [7:0]         point_duty;
      logic signed [12:0] temperature;
   } cmd_word_type;

   typedef struct {
      logic [1:0] status;
      logic [7:0] duty;
      logic [2:0] slot_id;
      logic [3:0] curve_count;
   } rsp_word_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [1:0]         req_action = 0;
   logic [7:0]         req_curve_id = 0;
   logic [3:0]         req_point_index = 0;
   logic [7:0]         req_point_count = 0;
   logic signed [12:0] req_point_temp = 0;
   logic [7:0]         req_point_duty = 0;
   logic signed [12:0] req_temperature = 0;
   logic               rsp_valid;
   logic [1:0]         rsp_status;
   logic [7:0]         rsp_duty;
   logic [2:0]         rsp_slot_id;
   logic [3:0]         rsp_curve_count;

   fan_curve_table_interpolator dut (.*);

   // predictor copy of the curve table
   int       tbl_temp [NCURVES*NPOINTS];
   int       tbl_duty [NCURVES*NPOINTS];
   int       tbl_npts [NCURVES];
   bit       tbl_used [NCURVES];
   int       used_cnt;
   int       open_slot;
   bit       open_flag;
   int       next_point;

   rsp_word_type expected_rsp[$];
   int           errors;
   int           items_sent;
   int           idle_pct;
   int           idle_cycles;

   initial forever #4 clock = ~clock;

   function automatic rsp_word_type curve_predict(cmd_word_type c);
      rsp_word_type r;
      int id, idx, cnt, slot, t, n, base, t0, t1, d0, d1, range;
      longint num;
      bit found;
      r.status = ST_OK;
      r.duty = 0;
      r.slot_id = 0;
      id = c.curve_id;
      idx = c.point_index;
      cnt = c.point_count;
      case (c.action)
         ACT_UPSERT: begin
            slot = -1;
            if (cnt == 0 || cnt > NPOINTS || idx >= cnt) begin
               open_flag = 0;
               r.status = ST_INVALID;
            end else if (idx == 0) begin
               open_flag = 0;
               if (id < NCURVES && tbl_used[id]) slot = id;
               else begin
                  for (int i = 0; i < NCURVES; i++)
                     if (slot < 0 && !tbl_used[i]) slot = i;
                  if (slot < 0) r.status = ST_NO_SPACE;
                  else begin
                     tbl_used[slot] = 1;
                     used_cnt++;
                  end
               end
            end else if (!open_flag || idx != next_point) begin
               open_flag = 0;
               r.status = ST_INVALID;
            end else slot = open_slot;
            if (r.status == ST_OK) begin
               tbl_temp[slot*NPOINTS+idx] = int'(c.point_temp);
               tbl_duty[slot*NPOINTS+idx] = c.point_duty;
               tbl_npts[slot] = idx + 1;
               open_slot = slot;
               next_point = idx + 1;
               open_flag = (idx + 1 < cnt);
               r.slot_id = slot;
            end
         end
         ACT_LOOKUP: begin
            t = int'(c.temperature);
            if (id >= NCURVES) r.status = ST_INVALID;
            else if (!tbl_used[id]) r.status = ST_NOT_FOUND;
            else begin
               n = tbl_npts[id];
               base = id * NPOINTS;
               if (t <= tbl_temp[base]) r.duty = tbl_duty[base];
               else if (t >= tbl_temp[base+n-1]) r.duty = tbl_duty[base+n-1];
               else begin
                  found = 0;
                  for (int i = 0; i + 1 < n; i++) begin
                     t0 = tbl_temp[base+i];
                     t1 = tbl_temp[base+i+1];
                     if (!found && t >= t0 && t <= t1) begin
                        found = 1;
                        d0 = tbl_duty[base+i];
                        d1 = tbl_duty[base+i+1];
                        range = t1 - t0;
                        if (range <= 0) r.duty = d0;
                        else begin
                           num = longint'(d0) * range + longint'(t - t0) * (d1 - d0);
                           if (num < 0) num = 0;
                           r.duty = 8'((num * 2 + range) / (longint'(range) * 2));
                        end
                     end
                  end
                  if (!found) r.status = ST_NOT_FOUND;
               end
            end
         end
         ACT_REMOVE: begin
            if (id >= NCURVES) r.status = ST_INVALID;
            else if (!tbl_used[id]) r.status = ST_NOT_FOUND;
            else begin
               tbl_used[id] = 0;
               tbl_npts[id] = 0;
               if (used_cnt > 0) used_cnt--;
               if (open_flag && open_slot == id) open_flag = 0;
            end
         end
         default: r.status = ST_INVALID;
      endcase
      if (r.status != ST_OK) begin
         r.duty = 0;
         r.slot_id = 0;
      end
      r.curve_count = 4'(used_cnt);
      return r;
   endfunction

   task automatic send_word(cmd_word_type c);
      if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1;
      req_action <= c.action;
      req_curve_id <= c.curve_id;
      req_point_index <= c.point_index;
      req_point_count <= c.point_count;
      req_point_temp <= c.point_temp;
      req_point_duty <= c.point_duty;
      req_temperature <= c.temperature;
      do @(posedge clock); while (busy);
      expected_rsp.push_back(curve_predict(c));
      items_sent++;
   endtask

   task automatic send_cmd(int act, int id, int idx, int cnt, int pt, int pd, int temp);
      cmd_word_type c;
      c.action = 2'(act);
      c.curve_id = 8'(id);
      c.point_index = 4'(idx);
      c.point_count = 8'(cnt);
      c.point_temp = 13'(pt);
      c.point_duty = 8'(pd);
      c.temperature = 13'(temp);
      send_word(c);
   endtask

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid) begin
         if (expected_rsp.size() == 0) report_mismatch("unexpected word", 1, 0);
         else begin
            e = expected_rsp.pop_front();
            if (rsp_status !== e.status) report_mismatch("status", rsp_status, e.status);
            if (rsp_duty !== e.duty) report_mismatch("duty", rsp_duty, e.duty);
            if (rsp_slot_id !== e.slot_id) report_mismatch("slot_id", rsp_slot_id, e.slot_id);
            if (rsp_curve_count !== e.curve_count)
               report_mismatch("curve_count", rsp_curve_count, e.curve_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic test_directed_errors;
      send_cmd(ACT_LOOKUP, 0, 0, 0, 0, 0, 0);
      send_cmd(ACT_LOOKUP, 255, 0, 0, 0, 0, 0);
      send_cmd(ACT_REMOVE, 9, 0, 0, 0, 0, 0);
      send_cmd(ACT_REMOVE, 0, 0, 0, 0, 0, 0);
      send_cmd(ACT_SPARE, 255, 15, 255, -1, 255, -1);
      send_cmd(ACT_UPSERT, 0, 0, 0, 0, 0, 0);
      send_cmd(ACT_UPSERT, 0, 0, 17, 0, 0, 0);
      send_cmd(ACT_UPSERT, 0, 5, 3, 0, 0, 0);
      send_cmd(ACT_UPSERT, 0, 1, 3, 0, 0, 0);
   endtask

   task automatic test_directed_curve;
      send_cmd(ACT_UPSERT, 255, 0, 3, -4096, 0, 0);
      send_cmd(ACT_UPSERT, 255, 1, 3, 0, 255, 0);
      send_cmd(ACT_UPSERT, 255, 2, 3, 4095, 10, 0);
      send_cmd(ACT_LOOKUP, 0, 0, 0, 0, 0, -4096);
      send_cmd(ACT_LOOKUP, 0, 0, 0, 0, 0, 4095);
      send_cmd(ACT_LOOKUP, 0, 0, 0, 0, 0, -2048);
      send_cmd(ACT_LOOKUP, 0, 0, 0, 0, 0, 100);
      // restart during an open upsert, then remove the slot being written
      send_cmd(ACT_UPSERT, 0, 0, 4, 5, 5, 0);
      send_cmd(ACT_UPSERT, 0, 0, 2, 10, 20, 0);
      send_cmd(ACT_REMOVE, 0, 0, 0, 0, 0, 0);
      send_cmd(ACT_UPSERT, 0, 1, 2, 30, 40, 0);
      // zero-width first segment, stored in slot 0; the lookup of id 1 finds no curve
      send_cmd(ACT_UPSERT, 1, 0, 16, 10, 77, 0);
      send_cmd(ACT_UPSERT, 1, 1, 16, 10, 99, 0);
      send_cmd(ACT_LOOKUP, 1, 0, 0, 0, 0, 10);
   endtask

   task automatic random_word;
      cmd_word_type c;
      c.action = 2'($urandom);
      c.curve_id = 8'($urandom);
      c.point_index = 4'($urandom);
      c.point_count = 8'($urandom);
      c.point_temp = 13'($urandom);
      c.point_duty = 8'($urandom);
      c.temperature = 13'($urandom);
      send_word(c);
   endtask

   task automatic random_upsert;
      int id, cnt, t, skip;
      id = ($urandom_range(1) != 0) ? $urandom_range(0, NCURVES-1) : $urandom_range(8, 255);
      cnt = ($urandom_range(9) == 0) ? $urandom_range(1, NPOINTS) : $urandom_range(1, 5);
      t = $signed($urandom_range(0, 8191)) - 4096;
      skip = ($urandom_range(19) == 0) ? $urandom_range(1, cnt) : -1;
      for (int i = 0; i < cnt; i++) begin
         if (i == skip) begin
            send_cmd(ACT_UPSERT, id, (i + 2) % 16, cnt, t, $urandom, 0);
            return;
         end
         send_cmd(ACT_UPSERT, id, i, cnt, t, $urandom, 0);
         if ($urandom_range(6) == 0) t = $signed($urandom_range(0, 8191)) - 4096;
         else t = t + $urandom_range(0, 600);
         if (t > 4095) t = 4095;
      end
   endtask

   task automatic random_lookup;
      int id, t, j;
      id = ($urandom_range(15) == 0) ? $urandom_range(8, 255) : $urandom_range(0, NCURVES-1);
      t = $signed($urandom_range(0, 8191)) - 4096;
      if (id < NCURVES && tbl_used[id] && $urandom_range(9) < 7) begin
         j = $urandom_range(0, tbl_npts[id] - 1);
         t = tbl_temp[id*NPOINTS+j] + $signed($urandom_range(0, 80)) - 40;
         if (t > 4095) t = 4095;
         if (t < -4096) t = -4096;
      end
      send_cmd(ACT_LOOKUP, id, $urandom, $urandom, $urandom, $urandom, t);
   endtask

   task automatic test_random(int n_items);
      int stop_at, r;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         r = $urandom_range(99);
         if (r < 40) random_upsert();
         else if (r < 78) random_lookup();
         else if (r < 90)
            send_cmd(ACT_REMOVE, ($urandom_range(9) == 0) ? $urandom_range(8, 255)
                     : $urandom_range(0, NCURVES-1), $urandom, $urandom, $urandom,
                     $urandom, $urandom);
         else random_word();
      end
   endtask

   initial begin
      int pct_set[4];
      pct_set = '{0, 62, 13, 0};
      errors = 0;
      items_sent = 0;
      idle_pct = 0;
      used_cnt = 0;
      open_slot = 0;
      open_flag = 0;
      next_point = 0;
      foreach (tbl_used[i]) begin
         tbl_used[i] = 0;
         tbl_npts[i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed_errors();
      test_directed_curve();
      foreach (pct_set[p]) begin
         idle_pct = pct_set[p];
         test_random(490);
      end
      start <= 0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/core/fcti_pkg.sv
rtl/core/fcti_ram.sv
rtl/core/fcti_datapath.sv
rtl/core/fcti_ctrl.sv
rtl/core/fan_curve_table_interpolator.sv
bench/fan_curve_table_interpolator_tb.sv
